// ===== design/twq_pkg.sv =====
// ----------------------------------------------------------------------------
// twq_pkg
// Types and codes shared by the thread wait queue and its controller.
// ----------------------------------------------------------------------------
package twq_pkg;

    localparam int PROC_W   = 8;
    localparam int KEY_W    = 16;
    localparam int SLEEP_W  = 16;
    localparam int OP_W     = 3;
    localparam int STAT_W   = 2;
    localparam int COUNT_W  = 5;

    // Released processes per tick are capped at this many results
    localparam int MAX_RUN  = 16;
    localparam int RUN_AW   = $clog2(MAX_RUN);
    localparam int RUN_CW   = $clog2(MAX_RUN + 1);

    localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [OP_W-1:0] OP_POP    = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
    localparam logic [OP_W-1:0] OP_FIND   = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK   = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NONE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [PROC_W-1:0]  proc;
        logic [KEY_W-1:0]   key;
        logic [SLEEP_W-1:0] sleep;
    } entry_t;

    typedef struct packed {
        logic               valid;
        logic [PROC_W-1:0]  proc;
        logic [STAT_W-1:0]  status;
        logic               empty;
        logic [COUNT_W-1:0] count;
        logic               last;
    } result_t;

endpackage

// ===== design/twq_ram.sv =====
// ----------------------------------------------------------------------------
// twq_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module twq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/twq_ctrl.sv =====
// ----------------------------------------------------------------------------
// twq_ctrl
// Sequencer for the wait queue: walks the entry memory one slot a cycle,
// compacts it in place and plays released processes out of the run buffer.
// ----------------------------------------------------------------------------
module twq_ctrl import twq_pkg::*; #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [OP_W-1:0]                  operation,
    input  logic [PROC_W-1:0]                process_ref,
    input  logic [KEY_W-1:0]                 thread_key,
    input  logic [SLEEP_W-1:0]               sleep_ticks,
    output logic                             q_we,
    output logic [$clog2(QUEUE_DEPTH)-1:0]   q_waddr,
    output entry_t                           q_wdata,
    output logic [$clog2(QUEUE_DEPTH)-1:0]   q_raddr,
    input  entry_t                           q_rdata,
    output logic                             r_we,
    output logic [RUN_AW-1:0]                r_waddr,
    output logic [PROC_W-1:0]                r_wdata,
    output logic [RUN_AW-1:0]                r_raddr,
    input  logic [PROC_W-1:0]                r_rdata,
    output result_t                          res
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    state_t              state_reg,   state_next;
    logic [OP_W-1:0]     op_reg,      op_next;
    logic [PROC_W-1:0]   proc_reg,    proc_next;
    logic [KEY_W-1:0]    key_reg,     key_next;
    logic [CW-1:0]       occ_reg,     occ_next;
    logic [CW-1:0]       issue_reg,   issue_next;
    logic                pend_reg,    pend_next;
    logic [AW-1:0]       cur_reg,     cur_next;
    logic                hit_reg,     hit_next;
    logic [PROC_W-1:0]   hproc_reg,   hproc_next;
    logic [CW-1:0]       wr_reg,      wr_next;
    logic [RUN_CW-1:0]   rel_reg,     rel_next;
    logic [RUN_CW-1:0]   em_issue_reg, em_issue_next;
    logic                em_pend_reg, em_pend_next;
    logic [RUN_AW-1:0]   em_cur_reg,  em_cur_next;
    result_t             out_reg,     out_next;

    logic                last_ent;
    logic                hit_now;
    logic [PROC_W-1:0]   hproc_now;
    logic [CW-1:0]       wr_now;
    logic [RUN_CW-1:0]   rel_now;
    logic                em_last;

    function automatic result_t make_res(
        input logic [PROC_W-1:0] p,
        input logic [STAT_W-1:0] s,
        input logic [CW-1:0]     n,
        input logic              l
    );
        result_t r;
        r.valid  = 1'b1;
        r.proc   = p;
        r.status = s;
        r.empty  = (n == '0);
        r.count  = COUNT_W'(n);
        r.last   = l;
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            occ_reg      <= '0;
            pend_reg     <= 1'b0;
            hit_reg      <= 1'b0;
            em_pend_reg  <= 1'b0;
            out_reg      <= '0;
            issue_reg    <= '0;
            wr_reg       <= '0;
            rel_reg      <= '0;
            em_issue_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            occ_reg      <= occ_next;
            pend_reg     <= pend_next;
            hit_reg      <= hit_next;
            em_pend_reg  <= em_pend_next;
            out_reg      <= out_next;
            issue_reg    <= issue_next;
            wr_reg       <= wr_next;
            rel_reg      <= rel_next;
            em_issue_reg <= em_issue_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        proc_reg   <= proc_next;
        key_reg    <= key_next;
        cur_reg    <= cur_next;
        hproc_reg  <= hproc_next;
        em_cur_reg <= em_cur_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        proc_next     = proc_reg;
        key_next      = key_reg;
        occ_next      = occ_reg;
        issue_next    = issue_reg;
        pend_next     = pend_reg;
        cur_next      = cur_reg;
        hit_next      = hit_reg;
        hproc_next    = hproc_reg;
        wr_next       = wr_reg;
        rel_next      = rel_reg;
        em_issue_next = em_issue_reg;
        em_pend_next  = em_pend_reg;
        em_cur_next   = em_cur_reg;
        out_next      = '0;

        q_we    = 1'b0;
        q_waddr = '0;
        q_wdata = q_rdata;
        q_raddr = issue_reg[AW-1:0];
        r_we    = 1'b0;
        r_waddr = rel_reg[RUN_AW-1:0];
        r_wdata = q_rdata.proc;
        r_raddr = em_issue_reg[RUN_AW-1:0];

        last_ent  = ((CW'(cur_reg) + CW'(1)) == occ_reg);
        hit_now   = hit_reg;
        hproc_now = hproc_reg;
        wr_now    = wr_reg;
        rel_now   = rel_reg;
        em_last   = ((RUN_CW'(em_cur_reg) + RUN_CW'(1)) == rel_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next    = operation;
                    proc_next  = process_ref;
                    key_next   = thread_key;
                    issue_next = '0;
                    pend_next  = 1'b0;
                    hit_next   = 1'b0;
                    wr_next    = '0;
                    rel_next   = '0;
                    if (operation == OP_PUSH)
                    begin
                        if (occ_reg < CW'(QUEUE_DEPTH))
                        begin
                            q_we          = 1'b1;
                            q_waddr       = occ_reg[AW-1:0];
                            q_wdata.proc  = process_ref;
                            q_wdata.key   = thread_key;
                            q_wdata.sleep = sleep_ticks;
                            occ_next      = occ_reg + CW'(1);
                            out_next      = make_res('0, STAT_OK, occ_reg + CW'(1), 1'b1);
                        end
                        else
                        begin
                            out_next = make_res('0, STAT_FULL, occ_reg, 1'b1);
                        end
                    end
                    else if (operation inside {OP_POP, OP_REMOVE, OP_FIND, OP_TICK})
                    begin
                        if (occ_reg == '0)
                        begin
                            out_next = make_res('0, STAT_NONE, occ_reg, 1'b1);
                        end
                        else
                        begin
                            state_next = ST_WALK;
                        end
                    end
                    else
                    begin
                        out_next = make_res('0, STAT_NONE, occ_reg, 1'b1);
                    end
                end
            end

            ST_WALK:
            begin
                // keep one read in flight ahead of the entry being handled
                if (issue_reg < occ_reg)
                begin
                    issue_next = issue_reg + CW'(1);
                    pend_next  = 1'b1;
                    cur_next   = issue_reg[AW-1:0];
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if (pend_reg)
                begin
                    case (op_reg)
                        OP_FIND:
                        begin
                            if (q_rdata.key == key_reg)
                            begin
                                out_next   = make_res(q_rdata.proc, STAT_OK, occ_reg, 1'b1);
                                state_next = ST_IDLE;
                            end
                            else if (last_ent)
                            begin
                                out_next   = make_res('0, STAT_NONE, occ_reg, 1'b1);
                                state_next = ST_IDLE;
                            end
                        end

                        OP_POP, OP_REMOVE:
                        begin
                            if (!hit_reg && (op_reg == OP_POP || q_rdata.proc == proc_reg))
                            begin
                                hit_now    = 1'b1;
                                hproc_now  = q_rdata.proc;
                                hit_next   = 1'b1;
                                hproc_next = q_rdata.proc;
                            end
                            else if (hit_reg)
                            begin
                                // close the gap: move this entry down one slot
                                q_we    = 1'b1;
                                q_waddr = cur_reg - AW'(1);
                            end
                            if (last_ent)
                            begin
                                state_next = ST_IDLE;
                                if (hit_now)
                                begin
                                    occ_next = occ_reg - CW'(1);
                                    out_next = make_res(hproc_now, STAT_OK,
                                                        occ_reg - CW'(1), 1'b1);
                                end
                                else
                                begin
                                    out_next = make_res('0, STAT_NONE, occ_reg, 1'b1);
                                end
                            end
                        end

                        OP_TICK:
                        begin
                            if (q_rdata.sleep == '0 && rel_reg < RUN_CW'(MAX_RUN))
                            begin
                                r_we    = 1'b1;
                                rel_now = rel_reg + RUN_CW'(1);
                            end
                            else
                            begin
                                q_we          = 1'b1;
                                q_waddr       = wr_reg[AW-1:0];
                                q_wdata.sleep = q_rdata.sleep
                                                - SLEEP_W'(q_rdata.sleep != '0);
                                wr_now        = wr_reg + CW'(1);
                            end
                            rel_next = rel_now;
                            wr_next  = wr_now;
                            if (last_ent)
                            begin
                                occ_next = wr_now;
                                if (rel_now == '0)
                                begin
                                    out_next   = make_res('0, STAT_NONE, wr_now, 1'b1);
                                    state_next = ST_IDLE;
                                end
                                else
                                begin
                                    em_issue_next = '0;
                                    em_pend_next  = 1'b0;
                                    state_next    = ST_EMIT;
                                end
                            end
                        end

                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_EMIT:
            begin
                if (em_issue_reg < rel_reg)
                begin
                    em_issue_next = em_issue_reg + RUN_CW'(1);
                    em_pend_next  = 1'b1;
                    em_cur_next   = em_issue_reg[RUN_AW-1:0];
                end
                else
                begin
                    em_pend_next = 1'b0;
                end

                if (em_pend_reg)
                begin
                    out_next = make_res(r_rdata, STAT_OK, occ_reg, em_last);
                    if (em_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign res  = out_reg;

endmodule

// ===== design/thread_wait_queue_with_sleep_timers.sv =====
// Push, unknown operations and any operation on an empty queue give their
// single result in the cycle after the start beat. Pop, remove, find and
// tick walk the entry memory one slot a cycle through its single read port,
// and a tick that releases entries then plays them out of the run buffer.
// Reset empties the queue but not the memory; results strobe once, no stall.
// Push takes a beat a cycle while idle; busy drops as a walk's last result shows.
// ----------------------------------------------------------------------------
// thread_wait_queue_with_sleep_timers
// Bounded FIFO of sleeping threads with removal by process, keyed lookup and tick release.
// ----------------------------------------------------------------------------
module thread_wait_queue_with_sleep_timers import twq_pkg::*; #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [OP_W-1:0]     operation,
    input  logic [PROC_W-1:0]   process_ref,
    input  logic [KEY_W-1:0]    thread_key,
    input  logic [SLEEP_W-1:0]  sleep_ticks,
    output logic                result_valid,
    output logic [PROC_W-1:0]   result_process,
    output logic [STAT_W-1:0]   status,
    output logic                queue_empty,
    output logic [COUNT_W-1:0]  entry_count,
    output logic                last_of_run
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    logic                q_we;
    logic [AW-1:0]       q_waddr;
    entry_t              q_wdata;
    logic [AW-1:0]       q_raddr;
    entry_t              q_rdata;
    logic                r_we;
    logic [RUN_AW-1:0]   r_waddr;
    logic [PROC_W-1:0]   r_wdata;
    logic [RUN_AW-1:0]   r_raddr;
    logic [PROC_W-1:0]   r_rdata;
    result_t             res;

    twq_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    twq_ram #(
        .WIDTH (PROC_W),
        .DEPTH (MAX_RUN)
    ) u_run_ram (
        .clk   (clk),
        .we    (r_we),
        .waddr (r_waddr),
        .wdata (r_wdata),
        .raddr (r_raddr),
        .rdata (r_rdata)
    );

    twq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .process_ref (process_ref),
        .thread_key  (thread_key),
        .sleep_ticks (sleep_ticks),
        .q_we        (q_we),
        .q_waddr     (q_waddr),
        .q_wdata     (q_wdata),
        .q_raddr     (q_raddr),
        .q_rdata     (q_rdata),
        .r_we        (r_we),
        .r_waddr     (r_waddr),
        .r_wdata     (r_wdata),
        .r_raddr     (r_raddr),
        .r_rdata     (r_rdata),
        .res         (res)
    );

    assign result_valid   = res.valid;
    assign result_process = res.proc;
    assign status         = res.status;
    assign queue_empty    = res.empty;
    assign entry_count    = res.count;
    assign last_of_run    = res.last;

    // a push is answered in the very next cycle
    a_push_answer: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && operation == OP_PUSH) |=> (result_valid && last_of_run))
        else $error("push beat not answered in the next cycle");

    // a run of released processes comes out without gaps
    a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last_of_run) |=> result_valid)
        else $error("gap inside a run of results");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && queue_empty) |-> (entry_count == '0))
        else $error("empty flag disagrees with entry count");

    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status == STAT_FULL) |-> !queue_empty)
        else $error("queue reported full and empty at once");

    // no new beat is taken while a result run is still pending
    a_busy_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last_of_run) |-> busy)
        else $error("idle while a run is still being delivered");

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the thread wait queue with sleep timers.
// Directed steps cover the empty and full queue, duplicates, misses,
// unknown operations and a full release run. Random traffic in fill, drain
// and mixed phases follows. Each start beat is predicted by an in-bench
// queue model, and every strobed result is matched field by field against
// the oldest pending expectation.
// ----------------------------------------------------------------------------
module tb import twq_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = 16;
    localparam int RANDOM_ITEMS = 500;
    localparam int QUIET_LIMIT  = 600;
    localparam int DRAIN_CYCLES = 40;
    localparam int PRINT_CAP    = 40;
    localparam int NUM_ROWS     = 16;

    // Codes the block does not define; it must answer them with a miss
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [PROC_W-1:0]  proc;
        logic [STAT_W-1:0]  status;
        logic               empty;
        logic [COUNT_W-1:0] count;
        logic               last;
    } queue_result_t;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [PROC_W-1:0]  proc;
        logic [KEY_W-1:0]   key;
        logic [SLEEP_W-1:0] ticks;
        logic [4:0]         reps;
        logic               typed;
        logic [PROC_W-1:0]  want_proc;
        logic [STAT_W-1:0]  want_status;
        logic [COUNT_W-1:0] want_count;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [OP_W-1:0]    operation;
    logic [PROC_W-1:0]  process_ref;
    logic [KEY_W-1:0]   thread_key;
    logic [SLEEP_W-1:0] sleep_ticks;
    logic               result_valid;
    logic [PROC_W-1:0]  result_process;
    logic [STAT_W-1:0]  status;
    logic               queue_empty;
    logic [COUNT_W-1:0] entry_count;
    logic               last_of_run;

    thread_wait_queue_with_sleep_timers #(
        .QUEUE_DEPTH (DEPTH)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .operation      (operation),
        .process_ref    (process_ref),
        .thread_key     (thread_key),
        .sleep_ticks    (sleep_ticks),
        .result_valid   (result_valid),
        .result_process (result_process),
        .status         (status),
        .queue_empty    (queue_empty),
        .entry_count    (entry_count),
        .last_of_run    (last_of_run)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Bench copy of the queue contents
    logic [PROC_W-1:0]  q_proc  [DEPTH];
    logic [KEY_W-1:0]   q_key   [DEPTH];
    logic [SLEEP_W-1:0] q_sleep [DEPTH];
    int                 q_len;

    queue_result_t      run_buf [MAX_RUN];
    queue_result_t      awaited_results [$];
    int                 mismatches;
    bit                 gaps_on;

    stim_row_t directed [NUM_ROWS] = '{
        '{OP_POP,      8'h00, 16'h0000, 16'h0000, 5'd1,  1'b1, 8'h00, STAT_NONE, 5'd0},
        '{OP_REMOVE,   8'hFF, 16'hFFFF, 16'hFFFF, 5'd1,  1'b1, 8'h00, STAT_NONE, 5'd0},
        '{OP_TICK,     8'h00, 16'h0000, 16'h0000, 5'd1,  1'b1, 8'h00, STAT_NONE, 5'd0},
        '{OP_SPARE_HI, 8'hFF, 16'hFFFF, 16'hFFFF, 5'd1,  1'b1, 8'h00, STAT_NONE, 5'd0},
        '{OP_PUSH,     8'hFF, 16'hFFFF, 16'hFFFF, 5'd1,  1'b1, 8'h00, STAT_OK,   5'd1},
        '{OP_PUSH,     8'h00, 16'h0000, 16'h0000, 5'd1,  1'b1, 8'h00, STAT_OK,   5'd2},
        '{OP_PUSH,     8'h5A, 16'h1234, 16'h0001, 5'd1,  1'b1, 8'h00, STAT_OK,   5'd3},
        '{OP_PUSH,     8'h5A, 16'h1234, 16'h0000, 5'd1,  1'b1, 8'h00, STAT_OK,   5'd4},
        '{OP_FIND,     8'h00, 16'h1234, 16'h0000, 5'd1,  1'b1, 8'h5A, STAT_OK,   5'd4},
        '{OP_FIND,     8'h00, 16'hBEEF, 16'h0000, 5'd1,  1'b1, 8'h00, STAT_NONE, 5'd4},
        '{OP_REMOVE,   8'h5A, 16'h0000, 16'h0000, 5'd1,  1'b1, 8'h5A, STAT_OK,   5'd3},
        '{OP_REMOVE,   8'h77, 16'h0000, 16'h0000, 5'd1,  1'b1, 8'h00, STAT_NONE, 5'd3},
        '{OP_TICK,     8'h00, 16'h0000, 16'h0000, 5'd1,  1'b0, 8'h00, STAT_OK,   5'd0},
        '{OP_POP,      8'h00, 16'h0000, 16'h0000, 5'd1,  1'b1, 8'hFF, STAT_OK,   5'd0},
        '{OP_PUSH,     8'h81, 16'h0081, 16'h0000, 5'd16, 1'b0, 8'h00, STAT_OK,   5'd0},
        '{OP_PUSH,     8'h3C, 16'hC3C3, 16'h0002, 5'd1,  1'b1, 8'h00, STAT_FULL, 5'd16}
    };

    task automatic note_mismatch(input string what);
        if (mismatches < PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic void drop_slot(input int idx);
        for (int i = idx; i + 1 < q_len; i++) begin
            q_proc[i]  = q_proc[i + 1];
            q_key[i]   = q_key[i + 1];
            q_sleep[i] = q_sleep[i + 1];
        end
        q_len--;
    endfunction

    // Apply one operation to the bench queue; results land in run_buf
    function automatic int apply_queue_op(input logic [OP_W-1:0] op,
                                          input logic [PROC_W-1:0] proc,
                                          input logic [KEY_W-1:0] key,
                                          input logic [SLEEP_W-1:0] ticks);
        int n;
        int w;
        int hit;
        n = 0;
        hit = -1;
        case (op)
            OP_PUSH:
            begin
                if (q_len < DEPTH) begin
                    q_proc[q_len]  = proc;
                    q_key[q_len]   = key;
                    q_sleep[q_len] = ticks;
                    q_len++;
                    run_buf[n++] = '{8'h00, STAT_OK, 1'b0, 5'd0, 1'b0};
                end
                else
                    run_buf[n++] = '{8'h00, STAT_FULL, 1'b0, 5'd0, 1'b0};
            end
            OP_POP:
            begin
                if (q_len == 0)
                    run_buf[n++] = '{8'h00, STAT_NONE, 1'b0, 5'd0, 1'b0};
                else begin
                    run_buf[n++] = '{q_proc[0], STAT_OK, 1'b0, 5'd0, 1'b0};
                    drop_slot(0);
                end
            end
            OP_REMOVE:
            begin
                for (int i = 0; i < q_len && hit < 0; i++)
                    if (q_proc[i] == proc)
                        hit = i;
                if (hit >= 0) begin
                    drop_slot(hit);
                    run_buf[n++] = '{proc, STAT_OK, 1'b0, 5'd0, 1'b0};
                end
                else
                    run_buf[n++] = '{8'h00, STAT_NONE, 1'b0, 5'd0, 1'b0};
            end
            OP_FIND:
            begin
                for (int i = 0; i < q_len && hit < 0; i++)
                    if (q_key[i] == key)
                        hit = i;
                if (hit >= 0)
                    run_buf[n++] = '{q_proc[hit], STAT_OK, 1'b0, 5'd0, 1'b0};
                else
                    run_buf[n++] = '{8'h00, STAT_NONE, 1'b0, 5'd0, 1'b0};
            end
            OP_TICK:
            begin
                w = 0;
                for (int i = 0; i < q_len; i++) begin
                    if (q_sleep[i] == 0 && n < MAX_RUN)
                        run_buf[n++] = '{q_proc[i], STAT_OK, 1'b0, 5'd0, 1'b0};
                    else begin
                        // compact the survivors while counting them down
                        if (q_sleep[i] != 0)
                            q_sleep[i] = q_sleep[i] - 1'b1;
                        q_proc[w]  = q_proc[i];
                        q_key[w]   = q_key[i];
                        q_sleep[w] = q_sleep[i];
                        w++;
                    end
                end
                q_len = w;
                if (n == 0)
                    run_buf[n++] = '{8'h00, STAT_NONE, 1'b0, 5'd0, 1'b0};
            end
            default:
                run_buf[n++] = '{8'h00, STAT_NONE, 1'b0, 5'd0, 1'b0};
        endcase
        for (int k = 0; k < n; k++) begin
            run_buf[k].empty = (q_len == 0);
            run_buf[k].count = q_len[COUNT_W-1:0];
            run_buf[k].last  = (k == n - 1);
        end
        return n;
    endfunction

    // Drive one beat, wait for it to be taken, then log what it should produce
    task automatic issue_op(input logic [OP_W-1:0] op, input logic [PROC_W-1:0] proc,
                            input logic [KEY_W-1:0] key, input logic [SLEEP_W-1:0] ticks,
                            input logic typed, input queue_result_t typed_res);
        int n;
        if (gaps_on && $urandom_range(0, 99) < 11) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start       <= 1'b1;
        operation   <= op;
        process_ref <= proc;
        thread_key  <= key;
        sleep_ticks <= ticks;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        n = apply_queue_op(op, proc, key, ticks);
        if (typed)
            awaited_results.push_back(typed_res);
        else
            for (int k = 0; k < n; k++)
                awaited_results.push_back(run_buf[k]);
    endtask

    always @(posedge clk) begin : result_check
        queue_result_t want;
        if (rst_n && result_valid) begin
            if (awaited_results.size() == 0)
                note_mismatch($sformatf("result with nothing pending: proc %0h status %0d",
                                        result_process, status));
            else begin
                want = awaited_results.pop_front();
                if (result_process !== want.proc)
                    note_mismatch($sformatf("result_process %0h, expected %0h",
                                            result_process, want.proc));
                if (status !== want.status)
                    note_mismatch($sformatf("status %0d, expected %0d", status, want.status));
                if (queue_empty !== want.empty)
                    note_mismatch($sformatf("queue_empty %0b, expected %0b",
                                            queue_empty, want.empty));
                if (entry_count !== want.count)
                    note_mismatch($sformatf("entry_count %0d, expected %0d",
                                            entry_count, want.count));
                if (last_of_run !== want.last)
                    note_mismatch($sformatf("last_of_run %0b, expected %0b",
                                            last_of_run, want.last));
            end
        end
    end

    // Abort if neither a start beat nor a result beat turns up for too long
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge clk);
            if ((start && !busy) || result_valid)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        queue_result_t      typed_res;
        logic [OP_W-1:0]    op;
        logic [PROC_W-1:0]  proc;
        logic [KEY_W-1:0]   key;
        logic [SLEEP_W-1:0] ticks;
        int                 push_pct;
        int                 pick;

        mismatches = 0;
        q_len      = 0;
        gaps_on    = 1'b1;
        push_pct   = 40;
        rst_n       <= 1'b0;
        start       <= 1'b0;
        operation   <= OP_PUSH;
        process_ref <= '0;
        thread_key  <= '0;
        sleep_ticks <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[r]) begin
            typed_res = '{directed[r].want_proc, directed[r].want_status,
                          directed[r].want_count == 0, directed[r].want_count, 1'b1};
            repeat (directed[r].reps)
                issue_op(directed[r].op, directed[r].proc, directed[r].key,
                         directed[r].ticks, directed[r].typed, typed_res);
        end
        // a queue full of zero sleeps empties in one run
        issue_op(OP_TICK, 8'h00, 16'h0000, 16'h0000, 1'b0, typed_res);
        issue_op(OP_SPARE_LO, 8'hA5, 16'h5A5A, 16'hA5A5, 1'b0, typed_res);

        for (int item = 0; item < RANDOM_ITEMS; item++) begin
            // hold a gap-free stretch in the middle of the run
            gaps_on = !(item >= 150 && item < 300);
            if (item % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0:       push_pct = 65;
                    1:       push_pct = 20;
                    default: push_pct = 40;
                endcase
            end
            proc  = PROC_W'($urandom_range(0, 255));
            key   = KEY_W'($urandom_range(0, 65535));
            ticks = SLEEP_W'($urandom_range(0, 65535));
            if ($urandom_range(0, 99) < 100 - push_pct) begin
                pick = $urandom_range(0, 19);
                if (pick < 3)
                    op = OP_POP;
                else if (pick < 6)
                    op = OP_REMOVE;
                else if (pick < 10)
                    op = OP_FIND;
                else if (pick < 19)
                    op = OP_TICK;
                else
                    op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
                // aim most lookups at live entries
                if (q_len > 0 && $urandom_range(0, 99) < 65) begin
                    pick = $urandom_range(0, q_len - 1);
                    proc = q_proc[pick];
                    key  = q_key[pick];
                end
            end
            else begin
                op = OP_PUSH;
                // a small pool of names makes duplicates common
                if ($urandom_range(0, 99) < 40)
                    proc = PROC_W'($urandom_range(0, 7));
                if ($urandom_range(0, 99) < 40)
                    key = KEY_W'($urandom_range(0, 7));
                pick = $urandom_range(0, 99);
                if (pick < 75)
                    ticks = SLEEP_W'($urandom_range(0, 3));
                else if (pick < 90)
                    ticks = SLEEP_W'($urandom_range(4, 40));
            end
            issue_op(op, proc, key, ticks, 1'b0, typed_res);
        end
        start <= 1'b0;

        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
